### sv/bsp_pkg.sv
package bsp_pkg;

  localparam int TIME_W      = 32;
  localparam int MEAS_W      = 16;
  localparam int FAULT_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CELL_INPUTS = 4;

  // Number of cell fields that take part in the voltage checks
  localparam int CELL_COUNT  = 4;
  localparam int CELL_CHECK  = (CELL_COUNT < CELL_INPUTS) ? CELL_COUNT : CELL_INPUTS;

  // Minimum time between two debounced switch changes, in ms
  localparam int unsigned DEBOUNCE_MS = 100;

  // Fault bit positions
  localparam int FB_SHORT       = 0;
  localparam int FB_OVERCURRENT = 1;
  localparam int FB_HOT         = 2;
  localparam int FB_WARM        = 3;
  localparam int FB_COLD        = 4;
  localparam int FB_COOL        = 5;
  localparam int FB_OVERVOLT    = 6;
  localparam int FB_UNDERVOLT   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERCURRENT_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIODE_CURRENT_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_HOT_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HOT_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_COLD_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_COLD_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HIGH_LIMIT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LOW_LIMIT       = 3'd7;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SHORT   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_CHG_ONLY = 2'd1,
    MODE_DSG_ONLY = 2'd2,
    MODE_OFF      = 2'd3
  } mode_t;

  typedef struct packed {
    logic        [MEAS_W-1:0] oc_lim;
    logic        [MEAS_W-1:0] diode_lim;
    logic signed [MEAS_W-1:0] dsg_hot;
    logic signed [MEAS_W-1:0] chg_hot;
    logic signed [MEAS_W-1:0] dsg_cold;
    logic signed [MEAS_W-1:0] chg_cold;
    logic        [MEAS_W-1:0] cell_high;
    logic        [MEAS_W-1:0] cell_low;
  } cfg_t;

  typedef struct packed {
    cmd_t                                 cmd;
    logic [TIME_W-1:0]                    time_ms;
    logic [MEAS_W-1:0]                    i_chg;
    logic [MEAS_W-1:0]                    i_dsg;
    logic signed [MEAS_W-1:0]             temp_a;
    logic signed [MEAS_W-1:0]             temp_b;
    logic [CELL_INPUTS-1:0][MEAS_W-1:0]   cells;
  } sample_t;

  // Sensor check outcome; the short bit position is always zero here
  typedef struct packed {
    logic               diode;
    logic [FAULT_W-1:0] fault;
  } eval_t;

  typedef struct packed {
    logic               charge_on;
    logic               discharge_on;
    logic [FAULT_W-1:0] fault_bits;
    mode_t              mode;
    logic               diode_active;
    logic               switched;
  } result_t;

endpackage

### sv/battery_switch_protection.sv
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  -----------------------------------------
// in_      input      in_valid / in_ready    cmd, time stamp, currents, temps, cells
// out_     output     out_valid / out_ready  switch drives, fault bits, mode, flags
// cfg_     input      cfg_valid / cfg_ready  register index, 16-bit limit value
//
// Each transfer passes through two registers on its way from input to result:
// the input register, then the compare/select logic into the result register.
// One item per cycle is sustained while out_ready stays high; the protection
// state updates as an item moves from the input register to the result register.
// rst_n is synchronous, active low; it clears both stage valids, the protection
// state and the limit registers to their defaults. A stall on out_ready holds
// the result register and, through it, the input register; cfg_ready is always high.
module battery_switch_protection #(
  parameter int unsigned DEBOUNCE_MS = bsp_pkg::DEBOUNCE_MS,
  parameter int          CELL_COUNT  = bsp_pkg::CELL_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic [bsp_pkg::TIME_W-1:0]     in_time_ms,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_current_charge,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_current_discharge,
  input  logic signed [bsp_pkg::MEAS_W-1:0] in_temp_a,
  input  logic signed [bsp_pkg::MEAS_W-1:0] in_temp_b,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_cell_voltage_0,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_cell_voltage_1,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_cell_voltage_2,
  input  logic [bsp_pkg::MEAS_W-1:0]     in_cell_voltage_3,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_charge_on,
  output logic                           out_discharge_on,
  output logic [bsp_pkg::FAULT_W-1:0]    out_fault_bits,
  output logic [1:0]                     out_mode,
  output logic                           out_diode_active,
  output logic                           out_switched,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::MEAS_W-1:0]     cfg_data
);

  logic               in_vld_r;
  bsp_pkg::sample_t   smp_r;
  logic               out_vld_r;
  bsp_pkg::result_t   res_r;

  bsp_pkg::cfg_t      cfg;
  bsp_pkg::eval_t     ev;
  bsp_pkg::result_t   res;
  logic               advance;

  // Move the held item into the result register when that register is free
  // or being drained this cycle.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign cfg_ready = 1'b1;

  // Input stage: valid is control, payload loads only on a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r.cmd      <= bsp_pkg::cmd_t'(in_cmd);
      smp_r.time_ms  <= in_time_ms;
      smp_r.i_chg    <= in_current_charge;
      smp_r.i_dsg    <= in_current_discharge;
      smp_r.temp_a   <= in_temp_a;
      smp_r.temp_b   <= in_temp_b;
      smp_r.cells[0] <= in_cell_voltage_0;
      smp_r.cells[1] <= in_cell_voltage_1;
      smp_r.cells[2] <= in_cell_voltage_2;
      smp_r.cells[3] <= in_cell_voltage_3;
    end
  end

  bsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Threshold checks on the held sample
  bsp_eval #(
    .CELL_COUNT (CELL_COUNT)
  ) u_eval (
    .smp (smp_r),
    .cfg (cfg),
    .ev  (ev)
  );

  // Fault latch, mode selection, debounce and switch registers
  bsp_ctl #(
    .DEBOUNCE_MS (DEBOUNCE_MS)
  ) u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .smp   (smp_r),
    .ev    (ev),
    .res   (res)
  );

  // Result stage: hold while stalled, drop valid once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_charge_on    = res_r.charge_on;
  assign out_discharge_on = res_r.discharge_on;
  assign out_fault_bits   = res_r.fault_bits;
  assign out_mode         = res_r.mode;
  assign out_diode_active = res_r.diode_active;
  assign out_switched     = res_r.switched;

endmodule

### sv/bsp_cfg.sv
module bsp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [bsp_pkg::MEAS_W-1:0]     wr_data,
  output bsp_pkg::cfg_t                  cfg
);

  bsp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_lim    <= 16'hFFFF;
      cfg_r.diode_lim <= 16'hFFFF;
      cfg_r.dsg_hot   <= 16'sd600;
      cfg_r.chg_hot   <= 16'sd450;
      cfg_r.dsg_cold  <= -16'sd200;
      cfg_r.chg_cold  <= 16'sd0;
      cfg_r.cell_high <= 16'd4200;
      cfg_r.cell_low  <= 16'd3000;
    end else if (wr_en) begin
      case (wr_idx)
        bsp_pkg::CFG_OVERCURRENT_LIMIT:    cfg_r.oc_lim    <= wr_data;
        bsp_pkg::CFG_DIODE_CURRENT_LIMIT:  cfg_r.diode_lim <= wr_data;
        bsp_pkg::CFG_DISCHARGE_HOT_LIMIT:  cfg_r.dsg_hot   <= wr_data;
        bsp_pkg::CFG_CHARGE_HOT_LIMIT:     cfg_r.chg_hot   <= wr_data;
        bsp_pkg::CFG_DISCHARGE_COLD_LIMIT: cfg_r.dsg_cold  <= wr_data;
        bsp_pkg::CFG_CHARGE_COLD_LIMIT:    cfg_r.chg_cold  <= wr_data;
        bsp_pkg::CFG_CELL_HIGH_LIMIT:      cfg_r.cell_high <= wr_data;
        bsp_pkg::CFG_CELL_LOW_LIMIT:       cfg_r.cell_low  <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/bsp_eval.sv
module bsp_eval #(
  parameter int CELL_COUNT = bsp_pkg::CELL_COUNT
) (
  input  bsp_pkg::sample_t smp,
  input  bsp_pkg::cfg_t    cfg,
  output bsp_pkg::eval_t   ev
);

  localparam int CELL_CHECK = (CELL_COUNT < bsp_pkg::CELL_INPUTS) ?
                              CELL_COUNT : bsp_pkg::CELL_INPUTS;

  logic        [bsp_pkg::MEAS_W-1:0] imax;
  logic signed [bsp_pkg::MEAS_W-1:0] tmax;
  logic signed [bsp_pkg::MEAS_W-1:0] tmin;
  logic                              over;
  logic                              under;

  assign imax = (smp.i_chg > smp.i_dsg) ? smp.i_chg : smp.i_dsg;
  assign tmax = (smp.temp_a > smp.temp_b) ? smp.temp_a : smp.temp_b;
  assign tmin = (smp.temp_a < smp.temp_b) ? smp.temp_a : smp.temp_b;

  always_comb begin
    over  = 1'b0;
    under = 1'b0;
    for (int i = 0; i < CELL_CHECK; i++) begin
      if (smp.cells[i] >= cfg.cell_high) over  = 1'b1;
      if (smp.cells[i] <= cfg.cell_low)  under = 1'b1;
    end
  end

  always_comb begin
    ev.fault                          = '0;
    ev.diode                          = (imax >= cfg.diode_lim);
    ev.fault[bsp_pkg::FB_OVERCURRENT] = (imax >= cfg.oc_lim);
    ev.fault[bsp_pkg::FB_HOT]         = (tmax > cfg.dsg_hot);
    ev.fault[bsp_pkg::FB_WARM]        = (tmax > cfg.chg_hot) && (tmax <= cfg.dsg_hot);
    ev.fault[bsp_pkg::FB_COLD]        = (tmin < cfg.dsg_cold);
    ev.fault[bsp_pkg::FB_COOL]        = (tmin >= cfg.dsg_cold) && (tmin < cfg.chg_cold);
    ev.fault[bsp_pkg::FB_OVERVOLT]    = over;
    ev.fault[bsp_pkg::FB_UNDERVOLT]   = under;
  end

endmodule

### sv/bsp_ctl.sv
module bsp_ctl #(
  parameter int unsigned DEBOUNCE_MS = bsp_pkg::DEBOUNCE_MS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bsp_pkg::sample_t  smp,
  input  bsp_pkg::eval_t    ev,
  output bsp_pkg::result_t  res
);

  logic [bsp_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic                        diode_r, diode_nxt;
  bsp_pkg::mode_t              held_r, held_nxt;
  logic                        chg_r, chg_nxt;
  logic                        dsg_r, dsg_nxt;
  logic [bsp_pkg::TIME_W-1:0]  last_r, last_nxt;

  logic [bsp_pkg::TIME_W-1:0]  elapsed;
  logic                        debounced;
  logic                        immediate;
  bsp_pkg::mode_t              pick;
  bsp_pkg::mode_t              res_mode;
  logic                        switched;

  assign elapsed   = smp.time_ms - last_r;
  assign debounced = (elapsed >= bsp_pkg::TIME_W'(DEBOUNCE_MS));
  assign immediate = (ev.diode != diode_r);

  // Fixed priority: trips, then body diode, then temperature band, then cells
  always_comb begin
    if (ev.fault[bsp_pkg::FB_OVERCURRENT] || ev.fault[bsp_pkg::FB_HOT] ||
        ev.fault[bsp_pkg::FB_COLD]) begin
      pick = bsp_pkg::MODE_OFF;
    end else if (ev.diode) begin
      pick = bsp_pkg::MODE_NORMAL;
    end else if (ev.fault[bsp_pkg::FB_WARM] || ev.fault[bsp_pkg::FB_COOL]) begin
      pick = bsp_pkg::MODE_DSG_ONLY;
    end else if (ev.fault[bsp_pkg::FB_UNDERVOLT]) begin
      pick = bsp_pkg::MODE_CHG_ONLY;
    end else if (ev.fault[bsp_pkg::FB_OVERVOLT]) begin
      pick = bsp_pkg::MODE_DSG_ONLY;
    end else begin
      pick = bsp_pkg::MODE_NORMAL;
    end
  end

  always_comb begin
    fault_nxt = fault_r;
    diode_nxt = diode_r;
    held_nxt  = held_r;
    chg_nxt   = chg_r;
    dsg_nxt   = dsg_r;
    last_nxt  = last_r;
    res_mode  = held_r;
    switched  = 1'b0;
    case (smp.cmd)
      bsp_pkg::CMD_SAMPLE: begin
        fault_nxt = {ev.fault[bsp_pkg::FAULT_W-1:1], fault_r[bsp_pkg::FB_SHORT]};
        diode_nxt = ev.diode;
        res_mode  = pick;
        if (immediate || (debounced && (pick != held_r))) begin
          chg_nxt  = (pick == bsp_pkg::MODE_NORMAL) || (pick == bsp_pkg::MODE_CHG_ONLY);
          dsg_nxt  = (pick == bsp_pkg::MODE_NORMAL) || (pick == bsp_pkg::MODE_DSG_ONLY);
          held_nxt = pick;
          last_nxt = smp.time_ms;
          switched = 1'b1;
        end
      end
      bsp_pkg::CMD_SHORT: begin
        fault_nxt[bsp_pkg::FB_SHORT] = 1'b1;
        chg_nxt = 1'b0;
        dsg_nxt = 1'b0;
      end
      bsp_pkg::CMD_RESTART: begin
        fault_nxt = '0;
        diode_nxt = 1'b0;
        chg_nxt   = 1'b0;
        dsg_nxt   = 1'b0;
        last_nxt  = smp.time_ms;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
      diode_r <= 1'b0;
      held_r  <= bsp_pkg::MODE_OFF;
      chg_r   <= 1'b0;
      dsg_r   <= 1'b0;
      last_r  <= '0;
    end else if (step) begin
      fault_r <= fault_nxt;
      diode_r <= diode_nxt;
      held_r  <= held_nxt;
      chg_r   <= chg_nxt;
      dsg_r   <= dsg_nxt;
      last_r  <= last_nxt;
    end
  end

  assign res.charge_on    = chg_nxt;
  assign res.discharge_on = dsg_nxt;
  assign res.fault_bits   = fault_nxt;
  assign res.mode         = res_mode;
  assign res.diode_active = diode_nxt;
  assign res.switched     = switched;

endmodule
